[rtl/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the serial frame parser
// Holds the frame geometry, the register indexes, the parser state type and
// the layout of one decoded frame.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int POS_W       = 5;
    localparam int XOR_BYTES   = 14;

    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] XOR_END_POS = POS_W'(XOR_BYTES);

    localparam logic [7:0] HEADER_RESET  = 8'hFF;
    localparam logic [7:0] TRAILER_RESET = 8'hEE;

    // Configuration register indexes.
    localparam logic REG_HEADER  = 1'b0;
    localparam logic REG_TRAILER = 1'b1;

    typedef enum logic [1:0] {
        ST_SEARCH,
        ST_HEADER_ONE,
        ST_BODY
    } parse_state_t;

    // One decoded frame, time_high in the lowest bits and channel_six in the highest.
    typedef struct packed {
        logic [7:0] channel_six;
        logic [7:0] channel_five;
        logic [7:0] channel_four;
        logic [7:0] channel_three;
        logic [7:0] channel_two;
        logic [7:0] channel_one;
        logic [7:0] time_low;
        logic [7:0] time_high;
    } frame_fields_t;

    // Result of one parser step handed to the output stage.
    typedef struct packed {
        logic          good;
        frame_fields_t fields;
    } step_result_t;

endpackage

[rtl/sfp_core.sv]
// ----------------------------------------------------------------------------
// sfp_core: header search, body capture and frame check
// Advances the parser by one byte whenever step is high and reports a good
// frame on the same cycle as its last byte.
// ----------------------------------------------------------------------------
module sfp_core import sfp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   header_byte,
    input  logic [7:0]   trailer_byte,
    output step_result_t result
);

    parse_state_t     state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       store_reg [FRAME_BYTES];
    logic             store_we;
    logic             frame_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEARCH;
            pos_reg   <= '0;
        end else if (step) begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Running checksum over bytes 0 to 13; cleared when a frame starts.
    always_ff @(posedge aclk) begin
        if (step) begin
            xor_reg <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && store_we) begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        store_we   = 1'b0;
        frame_ok   = 1'b0;
        unique case (state_reg)
            ST_SEARCH: begin
                if (rx_byte == header_byte) begin
                    state_next = ST_HEADER_ONE;
                end
            end
            ST_HEADER_ONE: begin
                if (rx_byte == header_byte) begin
                    state_next = ST_BODY;
                    pos_next   = '0;
                    xor_next   = '0;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_BODY: begin
                store_we = (pos_reg <= LAST_POS);
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < XOR_END_POS) begin
                    xor_next = xor_reg ^ rx_byte;
                end
                if (pos_reg == LAST_POS) begin
                    // The last byte is still on the input, not yet stored.
                    frame_ok   = (store_reg[15] == trailer_byte) &&
                                 (rx_byte == trailer_byte) &&
                                 (xor_reg == store_reg[14]);
                    state_next = ST_SEARCH;
                end
            end
            default: begin
                state_next = ST_SEARCH;
            end
        endcase
    end

    assign result.good                 = frame_ok;
    assign result.fields.time_high     = store_reg[2];
    assign result.fields.time_low      = store_reg[3];
    assign result.fields.channel_one   = store_reg[5];
    assign result.fields.channel_two   = store_reg[7];
    assign result.fields.channel_three = store_reg[9];
    assign result.fields.channel_four  = store_reg[11];
    assign result.fields.channel_five  = store_reg[13];
    assign result.fields.channel_six   = store_reg[15];

endmodule

[rtl/serial_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// serial_frame_parser_top: sync-header frame parser with XOR checksum
// Finds two header bytes, captures a 17-byte body, checks trailer and
// checksum, and emits the time index and six channel bytes of good frames.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload (lowest bit first)                     Words
//  s_axis    in   rx_byte                                        one per byte
//  m_axis    out  time_high, time_low, channel_one .. channel_six one per frame
//  cfg       in   index 0 header_byte, index 1 trailer_byte      single write
//
// The parser takes one byte every cycle while the output is free. A byte is
// first captured in an input register and is parsed once the output slot is
// free; a good frame's word is loaded into the output register at the edge
// where its last byte is parsed, and is offered on m_axis from there. Reset is
// synchronous and active low: it clears the parser to header search and both
// registers to their defaults. While a result waits untaken on m_axis the
// parser holds: the input register takes one more byte, and then the input
// stalls until the word is taken.
//
module serial_frame_parser_top import sfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] time_high, [15:8] time_low,
                                        // [23:16] channel_one, [31:24] channel_two,
                                        // [39:32] channel_three, [47:40] channel_four,
                                        // [55:48] channel_five, [63:56] channel_six

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wr_data
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg, out_valid_next;
    frame_fields_t out_data_reg;
    logic [7:0]    header_reg;
    logic [7:0]    trailer_reg;
    logic          out_free;
    logic          step;
    logic          s_accept;
    step_result_t  core_result;

    // Config registers. The user must write only while the parser is idle; unchecked.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= HEADER_RESET;
            trailer_reg <= TRAILER_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_HEADER) begin
                header_reg <= cfg_wr_data;
            end else begin
                trailer_reg <= cfg_wr_data;
            end
        end
    end

    // The output slot is free if it is empty or being emptied this cycle.
    // The held byte is parsed whenever the slot is free, so a byte that
    // finishes a good frame always has somewhere to put its result.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    sfp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .header_byte  (header_reg),
        .trailer_byte (trailer_reg),
        .result       (core_result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && core_result.good) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && core_result.good) begin
            out_data_reg <= core_result.fields;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/sfp_checker.sv]
// ----------------------------------------------------------------------------
// sfp_checker: port-level checks of the serial frame parser
// Watches the top level's ports and flags handshake and stall slips.
// ----------------------------------------------------------------------------
module sfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Reset empties the output slot.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word present after reset");

    // The input only stalls behind a result that is waiting to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with the output free");

    // A waiting result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word withdrawn before it was taken");

    // A waiting result does not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind serial_frame_parser_top sfp_checker u_sfp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the serial frame parser
// Feeds byte streams (clean frames, damaged frames, broken headers, noise)
// through s_axis, decodes the same bytes in a local frame decoder and checks
// each word taken from m_axis against the oldest decoded frame, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sfp_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off for back-pressure
    localparam int SETTLE_CYCLES = 4;     // margin for the pipeline to empty
    localparam int ITEM_TARGET   = 1200;
    localparam int BATCH_BYTES   = 200;
    localparam int SHOW_FAULTS   = 10;

    // Kinds of byte sequence that the stimulus is built from.
    typedef enum logic [2:0] {
        SEQ_NOISE,       // one stray byte, given by the argument
        SEQ_GOOD,        // clean frame with random content
        SEQ_FILLED,      // clean frame whose data bytes all equal the argument
        SEQ_BAD_SUM,     // checksum byte corrupted
        SEQ_BAD_TRAILER, // argument 0: byte 15, 1: byte 16, 2: both corrupted
        SEQ_BROKEN_HDR,  // one header byte followed by the argument
        SEQ_EXTRA_HDR,   // a third header byte ahead of a clean frame
        SEQ_TRUNCATED    // two headers and only as many body bytes as the argument
    } seq_kind_t;

    typedef struct packed {
        seq_kind_t   kind;
        logic [7:0]  arg;
        logic        typed;       // expectation written into the table
        logic        typed_hit;   // the table expects a decoded frame
        logic [63:0] typed_word;  // channel_six in the top byte, time_high at the bottom
    } probe_row_t;

    typedef struct {
        logic [7:0]    data;
        int            gap;
        bit            typed;
        bit            typed_hit;
        frame_fields_t typed_word;
    } rx_word_t;

    // Directed part, parsed with the reset values: header 0xFF, trailer 0xEE.
    // A filled frame has equal data bytes, a zero checksum and the trailer in
    // bytes 15 and 16, so its decoded word can be read straight off the row.
    localparam int PROBE_ROWS = 19;
    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{SEQ_NOISE,       8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_NOISE,       8'hFE, 1'b0, 1'b0, 64'h0},
        '{SEQ_FILLED,      8'h00, 1'b1, 1'b1, 64'hEE00_0000_0000_0000},
        '{SEQ_FILLED,      8'hFF, 1'b1, 1'b1, 64'hEEFF_FFFF_FFFF_FFFF},
        '{SEQ_BROKEN_HDR,  8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_FILLED,      8'h55, 1'b1, 1'b1, 64'hEE55_5555_5555_5555},
        '{SEQ_BROKEN_HDR,  8'h7F, 1'b0, 1'b0, 64'h0},
        '{SEQ_FILLED,      8'hAA, 1'b1, 1'b1, 64'hEEAA_AAAA_AAAA_AAAA},
        '{SEQ_BAD_SUM,     8'h00, 1'b1, 1'b0, 64'h0},
        '{SEQ_BAD_TRAILER, 8'h00, 1'b1, 1'b0, 64'h0},
        '{SEQ_BAD_TRAILER, 8'h01, 1'b1, 1'b0, 64'h0},
        '{SEQ_BAD_TRAILER, 8'h02, 1'b1, 1'b0, 64'h0},
        '{SEQ_FILLED,      8'hEE, 1'b1, 1'b1, 64'hEEEE_EEEE_EEEE_EEEE},
        '{SEQ_GOOD,        8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_EXTRA_HDR,   8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_GOOD,        8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_TRUNCATED,   8'h09, 1'b0, 1'b0, 64'h0},
        '{SEQ_GOOD,        8'h00, 1'b0, 1'b0, 64'h0},
        '{SEQ_GOOD,        8'h00, 1'b0, 1'b0, 64'h0}
    };

    string field_names [8] = '{"time_high", "time_low", "channel_one", "channel_two",
                               "channel_three", "channel_four", "channel_five",
                               "channel_six"};

    // Clock, reset and the block's ports; every input is known from time zero.
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_index     = REG_HEADER;
    logic [7:0]  cfg_wr_data   = 8'h00;

    // Local frame decoder: its own copy of the registers and parser state.
    logic [7:0]   sync_byte;
    logic [7:0]   end_byte;
    parse_state_t parse_st;
    logic [4:0]   body_pos;
    logic [7:0]   body_copy [FRAME_BYTES];

    rx_word_t      rx_stream [$];   // bytes waiting to be offered on s_axis
    frame_fields_t due_frames [$];  // decoded frames not yet seen on m_axis

    int  cycle_count   = 0;
    int  fault_count   = 0;
    int  frames_taken  = 0;
    int  bytes_sent    = 0;
    int  bytes_queued  = 0;
    int  settings_used = 1;
    bit  hold_req      = 1'b0;
    bit  hold_active   = 1'b0;
    int  holds_done    = 0;

    logic [63:0] got_word;
    logic [63:0] want_word;

    always #5 aclk = ~aclk;

    serial_frame_parser_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] time_high .. [63:56] channel_six
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Advances the local decoder by one accepted byte. Returns 1 when the byte
    // completes a frame whose trailer and checksum are both correct.
    function automatic bit parse_byte(input logic [7:0] b, output frame_fields_t f);
        logic [7:0] sum;
        bit         good;
        good = 1'b0;
        sum  = '0;
        f    = '0;
        case (parse_st)
            ST_SEARCH: begin
                if (b == sync_byte) parse_st = ST_HEADER_ONE;
            end
            ST_HEADER_ONE: begin
                // A second byte that is not a header sends us straight back to
                // search; it is not reconsidered as a first header.
                if (b == sync_byte) begin
                    parse_st = ST_BODY;
                    body_pos = '0;
                end else begin
                    parse_st = ST_SEARCH;
                end
            end
            default: begin
                body_copy[body_pos] = b;
                body_pos = body_pos + 5'd1;
                if (body_pos == POS_W'(FRAME_BYTES)) begin
                    for (int k = 0; k < XOR_BYTES; k++) sum ^= body_copy[k];
                    good = body_copy[LAST_POS] == end_byte &&
                           body_copy[LAST_POS - 1] == end_byte &&
                           sum == body_copy[XOR_END_POS];
                    f.time_high     = body_copy[2];
                    f.time_low      = body_copy[3];
                    f.channel_one   = body_copy[5];
                    f.channel_two   = body_copy[7];
                    f.channel_three = body_copy[9];
                    f.channel_four  = body_copy[11];
                    f.channel_five  = body_copy[13];
                    f.channel_six   = body_copy[15];
                    parse_st = ST_SEARCH;
                end
            end
        endcase
        return good;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random byte, leaning towards the current header and trailer values so
    // that they also turn up inside frame bodies and as noise.
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0) return sync_byte;
        if (r == 1) return end_byte;
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_word(input logic [7:0] d, input bit calm);
        rx_word_t w;
        w.data       = d;
        w.gap        = calm ? 0 : idle_cycles();
        w.typed      = 1'b0;
        w.typed_hit  = 1'b0;
        w.typed_word = '0;
        rx_stream.push_back(w);
    endfunction

    // Appends one byte sequence of the given kind to the stream. Frames are
    // built against the register values that the decoder currently holds.
    function automatic void add_sequence(input seq_kind_t kind, input logic [7:0] arg,
                                         input bit calm);
        logic [7:0] body [FRAME_BYTES];
        logic [7:0] sum;
        int         count;
        int         start_size;
        sum        = '0;
        count      = FRAME_BYTES;
        start_size = rx_stream.size();
        for (int k = 0; k < FRAME_BYTES; k++) body[k] = (kind == SEQ_FILLED) ? arg : rand_byte();
        for (int k = 0; k < XOR_BYTES; k++) sum ^= body[k];
        body[XOR_END_POS]  = sum;
        body[LAST_POS - 1] = end_byte;
        body[LAST_POS]     = end_byte;
        case (kind)
            SEQ_BAD_SUM: body[XOR_END_POS] ^= 8'($urandom_range(254) + 1);
            SEQ_BAD_TRAILER: begin
                if (arg != 8'd1) body[LAST_POS - 1] ^= 8'($urandom_range(254) + 1);
                if (arg != 8'd0) body[LAST_POS]     ^= 8'($urandom_range(254) + 1);
            end
            SEQ_TRUNCATED: count = int'(arg);
            default: ;
        endcase
        case (kind)
            SEQ_NOISE: push_word(arg, calm);
            SEQ_BROKEN_HDR: begin
                push_word(sync_byte, calm);
                push_word(arg, calm);
            end
            default: begin
                if (kind == SEQ_EXTRA_HDR) push_word(sync_byte, calm);
                push_word(sync_byte, calm);
                push_word(sync_byte, calm);
                for (int k = 0; k < count; k++) push_word(body[k], calm);
            end
        endcase
        bytes_queued += rx_stream.size() - start_size;
    endfunction

    // Offers the queued bytes on s_axis. Each byte is decoded locally at the
    // edge where it is accepted; tvalid stays high between back-to-back bytes.
    task automatic play_stream();
        rx_word_t      w;
        frame_fields_t f;
        bit            hit;
        while (rx_stream.size() > 0) begin
            w = rx_stream.pop_front();
            if (w.gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (w.gap) @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= w.data;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            hit = parse_byte(w.data, f);
            if (w.typed) begin
                if (w.typed_hit) due_frames.push_back(w.typed_word);
            end else if (hit) begin
                due_frames.push_back(f);
            end
            bytes_sent++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every decoded frame has come out, then lets the pipeline
    // empty, since a byte that completes nothing may still be in flight.
    task automatic settle();
        while (due_frames.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers, header first and then trailer, only while idle.
    task automatic load_registers(input logic [7:0] header_val, input logic [7:0] trailer_val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_HEADER;
        cfg_wr_data <= header_val;
        @(posedge aclk);
        cfg_index   <= REG_TRAILER;
        cfg_wr_data <= trailer_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sync_byte = header_val;
        end_byte  = trailer_val;
        settings_used++;
    endtask

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames still due",
                     cycle_count, due_frames.size());
            $display("serial_frame_parser_top test failed");
            $finish;
        end
    end

    // Output checker: every word taken from m_axis must match the oldest
    // decoded frame, and a word with nothing due is a failure by itself.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_word = m_axis_tdata;
            frames_taken++;
            if (due_frames.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_FAULTS)
                    $display("Unexpected word on m_axis at cycle %0d: %h",
                             cycle_count, got_word);
            end else begin
                want_word = due_frames.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got_word[8*i +: 8] !== want_word[8*i +: 8]) begin
                        fault_count++;
                        if (fault_count <= SHOW_FAULTS)
                            $display("Mismatch in %s at cycle %0d: expected %h, got %h",
                                     field_names[i], cycle_count,
                                     want_word[8*i +: 8], got_word[8*i +: 8]);
                    end
                end
            end
        end
    end

    // Receiver: random stalls of varying length, long runs without any, and
    // on request one long hold-off so that the parser has to stall its input.
    initial begin
        int stall;
        int run;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
                holds_done++;
            end else begin
                stall = idle_cycles();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            run = ($urandom_range(9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    // Main sequence: reset, the directed table, then random phases under a
    // range of register settings, each phase started only once all is idle.
    initial begin
        int         r;
        int         phase;
        bit         calm;
        logic [7:0] pick;

        sync_byte = HEADER_RESET;
        end_byte  = TRAILER_RESET;
        parse_st  = ST_SEARCH;
        body_pos  = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table with the register values from reset.
        for (int i = 0; i < PROBE_ROWS; i++) begin
            add_sequence(probe_rows[i].kind, probe_rows[i].arg, 1'b0);
            if (probe_rows[i].typed) begin
                rx_stream[rx_stream.size() - 1].typed      = 1'b1;
                rx_stream[rx_stream.size() - 1].typed_hit  = probe_rows[i].typed_hit;
                rx_stream[rx_stream.size() - 1].typed_word = probe_rows[i].typed_word;
            end
        end
        play_stream();
        settle();

        // Random phases. The settings cycle through equal and opposite extremes
        // before random values, including a header equal to the trailer.
        phase = 0;
        while (bytes_queued < ITEM_TARGET) begin
            case (phase % 6)
                0: load_registers(8'h00, 8'h00);
                1: load_registers(8'hFF, 8'h00);
                2: load_registers(8'h00, 8'hFF);
                3: load_registers(8'hFF, 8'hFF);
                4: load_registers(8'($urandom_range(255)), 8'($urandom_range(255)));
                default: begin
                    pick = 8'($urandom_range(255));
                    load_registers(pick, pick);
                end
            endcase

            // In the first phase a burst of clean frames meets a long receiver
            // hold-off, so the output fills and the input has to stall.
            if (phase == 0) begin
                repeat (6) add_sequence(SEQ_GOOD, 8'h00, 1'b1);
            end

            // Mostly well-formed frames with random content; the rest is noise,
            // damaged frames, broken and repeated headers and cut-off frames.
            while (rx_stream.size() < BATCH_BYTES) begin
                r    = $urandom_range(99);
                calm = ($urandom_range(4) == 0);
                if (r < 55)      add_sequence(SEQ_GOOD, 8'h00, calm);
                else if (r < 65) add_sequence(SEQ_BAD_SUM, 8'h00, calm);
                else if (r < 75) add_sequence(SEQ_BAD_TRAILER, 8'($urandom_range(2)), calm);
                else if (r < 85) repeat ($urandom_range(1, 5)) add_sequence(SEQ_NOISE, rand_byte(), calm);
                else if (r < 92) add_sequence(SEQ_BROKEN_HDR, rand_byte(), calm);
                else if (r < 96) add_sequence(SEQ_TRUNCATED, 8'($urandom_range(1, 16)), calm);
                else             add_sequence(SEQ_EXTRA_HDR, 8'h00, calm);
            end

            if (phase == 0) begin
                hold_req = 1'b1;
                wait (hold_active);
            end
            play_stream();
            settle();
            phase++;
        end

        $display("Run covered %0d bytes over %0d register settings; %0d decoded frames checked.",
                 bytes_sent, settings_used, frames_taken);
        $display("Long receiver hold-offs with the input offering bytes: %0d; faults: %0d.",
                 holds_done, fault_count);
        if (fault_count == 0) begin
            $display("serial_frame_parser_top test passed");
        end else begin
            $display("serial_frame_parser_top test failed");
        end
        $finish;
    end

endmodule
